// ----- rtl/r2fft_pkg.sv -----
// shared types, constants and the twiddle octant table of the radix-2 fft unit
// no dependencies
package r2fft_pkg;

    localparam int LOG_MAX   = 10;
    localparam int PTS       = 1 << LOG_MAX;
    localparam int AW        = LOG_MAX;
    localparam int CW        = LOG_MAX + 1;
    localparam int DW        = 40;
    localparam int SW        = 24;
    localparam int TW        = 18;
    localparam int FRAC      = TW - 1;
    localparam int TWI_AW    = LOG_MAX - 1;
    localparam int OCT_N     = (PTS / 8) + 1;
    localparam int OCT_W     = TW + 1;

    localparam logic [1:0] REG_LOG_POINTS = 2'd0;
    localparam logic [1:0] REG_INVERSE    = 2'd1;

    localparam logic [63:0] PI4_Q60 = 64'h0C90FDAA22168C23;
    localparam logic [63:0] DIV_S [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                           64'd156, 64'd210};
    localparam logic [63:0] DIV_C [1:7] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                           64'd132, 64'd182};

    typedef logic [2*OCT_W-1:0] oct_entry_t;
    typedef oct_entry_t oct_rom_t [0:OCT_N-1];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_BF_RDA,
        ST_BF_RDB,
        ST_BF_MUL,
        ST_BF_RND,
        ST_BF_WRA,
        ST_BF_WRB,
        ST_SC_RD,
        ST_SC_WR
    } state_t;

    typedef struct packed {
        logic cap_a;
        logic mul_en;
        logic rnd_en;
        logic wr_a;
    } bf_ctrl_t;

    // cos and sin of (pi/4)*r/PTS by truncated taylor series, {cos, sin}
    function automatic oct_entry_t oct_entry(input int j);
        logic [63:0] r, q, rr, phi, x, x2, ts, tc;
        longint      ss, cc;
        logic [63:0] s_u, c_u;
        r   = 64'(8 * j);
        q   = PI4_Q60 >> LOG_MAX;
        rr  = PI4_Q60 & 64'(PTS - 1);
        phi = q * r + ((rr * r) >> LOG_MAX);
        x   = (phi + (64'd1 << 28)) >> 29;
        x2  = (x * x) >> 31;
        ts  = x;
        tc  = 64'd1 << 31;
        ss  = longint'(ts);
        cc  = longint'(tc);
        for (int k = 1; k <= 7; k++) begin
            ts = ((ts * x2) >> 31) / DIV_S[k];
            tc = ((tc * x2) >> 31) / DIV_C[k];
            if ((k % 2) == 1) begin
                ss = ss - longint'(ts);
                cc = cc - longint'(tc);
            end else begin
                ss = ss + longint'(ts);
                cc = cc + longint'(tc);
            end
        end
        if (ss < 0) ss = 0;
        if (cc < 0) cc = 0;
        s_u = (64'(ss) + (64'd1 << (31 - FRAC - 1))) >> (31 - FRAC);
        c_u = (64'(cc) + (64'd1 << (31 - FRAC - 1))) >> (31 - FRAC);
        return {c_u[OCT_W-1:0], s_u[OCT_W-1:0]};
    endfunction

    function automatic oct_rom_t build_oct_rom();
        oct_rom_t rom;
        for (int j = 0; j < OCT_N; j++) begin
            rom[j] = oct_entry(j);
        end
        return rom;
    endfunction

    localparam oct_rom_t OCT_ROM = build_oct_rom();

    // clamp a widened twiddle component back to TW bits
    function automatic logic signed [TW-1:0] tclamp(input logic signed [TW+1:0] v);
        logic signed [TW+1:0] hi, lo;
        hi = (TW+2)'((1 << (TW - 1)) - 1);
        lo = -hi - (TW+2)'(1);
        if (v > hi) begin
            return hi[TW-1:0];
        end else if (v < lo) begin
            return lo[TW-1:0];
        end
        return v[TW-1:0];
    endfunction

endpackage

// ----- rtl/r2fft_store.sv -----
// point store: single write port, single read port with registered read data
// depends on r2fft_pkg
module r2fft_store (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [r2fft_pkg::AW-1:0]      waddr,
    input  logic [2*r2fft_pkg::DW-1:0]    wdata,
    input  logic [r2fft_pkg::AW-1:0]      raddr,
    output logic [2*r2fft_pkg::DW-1:0]    rdata
);

    logic [2*r2fft_pkg::DW-1:0] mem [0:r2fft_pkg::PTS-1];
    logic [2*r2fft_pkg::DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/r2fft_twiddle.sv -----
// twiddle lookup: octant table unfolded over a half circle, conjugated for inverse
// depends on r2fft_pkg
module r2fft_twiddle (
    input  logic                              aclk,
    input  logic [r2fft_pkg::TWI_AW-1:0]      idx,
    input  logic                              inverse,
    output logic signed [r2fft_pkg::TW-1:0]   w_real,
    output logic signed [r2fft_pkg::TW-1:0]   w_imag
);

    localparam int OW = r2fft_pkg::OCT_W;
    localparam int TW = r2fft_pkg::TW;
    localparam int RB = r2fft_pkg::TWI_AW - 2;

    logic [RB:0]                 oct_idx;
    r2fft_pkg::oct_entry_t       ent;
    logic signed [TW+1:0]        c, s, co, si;
    logic signed [TW-1:0]        wr_c, wi_c, wi_f;
    logic signed [TW-1:0]        w_real_reg, w_imag_reg;

    always_comb begin
        // odd octants run backwards through the table
        if (idx[RB]) begin
            oct_idx = (RB+1)'((1 << RB) - idx[RB-1:0]);
        end else begin
            oct_idx = {1'b0, idx[RB-1:0]};
        end
        ent = r2fft_pkg::OCT_ROM[oct_idx];
        c   = signed'({1'b0, ent[2*OW-1:OW]});
        s   = signed'({1'b0, ent[OW-1:0]});
        unique case (idx[RB+1:RB])
            2'd0: begin co = c;  si = s; end
            2'd1: begin co = s;  si = c; end
            2'd2: begin co = -s; si = c; end
            default: begin co = -c; si = s; end
        endcase
        wr_c = r2fft_pkg::tclamp(co);
        wi_c = r2fft_pkg::tclamp(si);
        if (inverse) begin
            wi_f = r2fft_pkg::tclamp(-((TW+2)'(wi_c)));
        end else begin
            wi_f = wi_c;
        end
    end

    always_ff @(posedge aclk) begin
        w_real_reg <= wr_c;
        w_imag_reg <= wi_f;
    end

    assign w_real = w_real_reg;
    assign w_imag = w_imag_reg;

endmodule

// ----- rtl/r2fft_bfly.sv -----
// butterfly datapath: complex multiply, rounding, saturating sum and difference
// depends on r2fft_pkg
module r2fft_bfly (
    input  logic                              aclk,
    input  r2fft_pkg::bf_ctrl_t               ctrl,
    input  logic [2*r2fft_pkg::DW-1:0]        rdata,
    input  logic signed [r2fft_pkg::TW-1:0]   w_real,
    input  logic signed [r2fft_pkg::TW-1:0]   w_imag,
    output logic [2*r2fft_pkg::DW-1:0]        sum_data,
    output logic [2*r2fft_pkg::DW-1:0]        diff_data,
    output logic                              sat
);

    localparam int DW = r2fft_pkg::DW;
    localparam int PW = DW + r2fft_pkg::TW;
    localparam int FR = r2fft_pkg::FRAC;
    localparam int RW = PW + 2;
    localparam int HW = RW - FR;

    logic signed [DW-1:0]   a_re_reg, a_im_reg, x_re, x_im;
    logic signed [PW-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [DW-1:0]   t_re_reg, t_im_reg, t_re_next, t_im_next;
    logic                   rsat_reg, rsat_next;
    logic [2*DW-1:0]        diff_reg;
    logic signed [RW-1:0]   r_re, r_im;
    logic signed [HW-1:0]   h_re, h_im;
    logic signed [DW:0]     s_re, s_im, d_re, d_im;
    logic signed [DW-1:0]   so_re, so_im, do_re, do_im;
    logic                   sat_re, sat_im, ssat;

    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    assign x_re = signed'(rdata[2*DW-1:DW]);
    assign x_im = signed'(rdata[DW-1:0]);

    always_comb begin
        // exact sums of partial products, round half up, drop fraction bits
        r_re = RW'(p_rr_reg) - RW'(p_ii_reg) + RW'(1 << (FR - 1));
        r_im = RW'(p_ri_reg) + RW'(p_ir_reg) + RW'(1 << (FR - 1));
        h_re = r_re[RW-1:FR];
        h_im = r_im[RW-1:FR];
        sat_re = (h_re > HW'(DMAX)) || (h_re < HW'(DMIN));
        sat_im = (h_im > HW'(DMAX)) || (h_im < HW'(DMIN));
        t_re_next = sat_re ? (h_re[HW-1] ? DMIN : DMAX) : h_re[DW-1:0];
        t_im_next = sat_im ? (h_im[HW-1] ? DMIN : DMAX) : h_im[DW-1:0];
        rsat_next = sat_re || sat_im;

        s_re = (DW+1)'(a_re_reg) + (DW+1)'(t_re_reg);
        s_im = (DW+1)'(a_im_reg) + (DW+1)'(t_im_reg);
        d_re = (DW+1)'(a_re_reg) - (DW+1)'(t_re_reg);
        d_im = (DW+1)'(a_im_reg) - (DW+1)'(t_im_reg);
        so_re = (s_re[DW] != s_re[DW-1]) ? (s_re[DW] ? DMIN : DMAX) : s_re[DW-1:0];
        so_im = (s_im[DW] != s_im[DW-1]) ? (s_im[DW] ? DMIN : DMAX) : s_im[DW-1:0];
        do_re = (d_re[DW] != d_re[DW-1]) ? (d_re[DW] ? DMIN : DMAX) : d_re[DW-1:0];
        do_im = (d_im[DW] != d_im[DW-1]) ? (d_im[DW] ? DMIN : DMAX) : d_im[DW-1:0];
        ssat = (s_re[DW] != s_re[DW-1]) || (s_im[DW] != s_im[DW-1]) ||
               (d_re[DW] != d_re[DW-1]) || (d_im[DW] != d_im[DW-1]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cap_a) begin
            a_re_reg <= x_re;
            a_im_reg <= x_im;
        end
        if (ctrl.mul_en) begin
            p_rr_reg <= w_real * x_re;
            p_ii_reg <= w_imag * x_im;
            p_ri_reg <= w_real * x_im;
            p_ir_reg <= w_imag * x_re;
        end
        if (ctrl.rnd_en) begin
            t_re_reg <= t_re_next;
            t_im_reg <= t_im_next;
            rsat_reg <= rsat_next;
        end
        if (ctrl.wr_a) begin
            diff_reg <= {do_re, do_im};
        end
    end

    assign sum_data  = {so_re, so_im};
    assign diff_data = diff_reg;
    assign sat       = rsat_reg || ssat;

endmodule

// ----- rtl/radix2_complex_fft_unit.sv -----
// top level of the radix-2 decimation-in-time fft unit: control sequencer and ports
// depends on r2fft_pkg, r2fft_store, r2fft_twiddle, r2fft_bfly
// a load is written to the point store as it is accepted; a read passes through the store read
// register and the output register, one request at a time; the load that ends a block starts
// the transform: zero-fill of the remaining points, n/2 * log2 n butterflies (read a, read b,
// multiply, round, write a, write b, over the single write port) and inverse scaling per point
// reset clears control state and the load and read counters; store contents stay undefined, no clearing pass
module radix2_complex_fft_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [3:0]                        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic signed [r2fft_pkg::SW-1:0]   s_sample_real,
    input  logic signed [r2fft_pkg::SW-1:0]   s_sample_imag,
    input  logic                              s_last_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [r2fft_pkg::DW-1:0]   m_point_real,
    output logic signed [r2fft_pkg::DW-1:0]   m_point_imag,
    output logic                              m_last_point,
    output logic                              m_no_data,
    output logic                              m_saturated
);

    localparam int AW = r2fft_pkg::AW;
    localparam int CW = r2fft_pkg::CW;
    localparam int DW = r2fft_pkg::DW;
    localparam int KW = r2fft_pkg::TWI_AW;

    r2fft_pkg::state_t      state_reg, state_next;
    logic [3:0]             log_points_reg, log_points_next;
    logic                   inverse_reg, inverse_next;
    logic [CW-1:0]          load_count_reg, load_count_next;
    logic [CW-1:0]          read_count_reg, read_count_next;
    logic                   results_ready_reg, results_ready_next;
    logic                   overflow_reg, overflow_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [3:0]             stage_reg, stage_next;
    logic                   last_pt_reg, last_pt_next;

    logic                   m_valid_reg, m_valid_next;
    logic signed [DW-1:0]   m_point_real_reg, m_point_real_next;
    logic signed [DW-1:0]   m_point_imag_reg, m_point_imag_next;
    logic                   m_last_point_reg, m_last_point_next;
    logic                   m_no_data_reg, m_no_data_next;
    logic                   m_saturated_reg, m_saturated_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [2*DW-1:0]        mem_wdata, mem_rdata;
    logic [2*DW-1:0]        sum_data, diff_data;
    logic                   bf_sat;
    r2fft_pkg::bf_ctrl_t    bf_ctrl;
    logic signed [r2fft_pkg::TW-1:0] w_real, w_imag;

    logic [3:0]             lg;
    logic [CW-1:0]          n_pts, half_n, new_cnt;
    logic [AW-1:0]          low_mask, j_addr, j2_addr;
    logic [KW-1:0]          tw_idx;
    logic                   s_acc;
    logic signed [DW-1:0]   sc_re, sc_im;

    function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] i, input logic [3:0] l);
        logic [AW-1:0] r;
        for (int b = 0; b < AW; b++) begin
            r[b] = i[AW-1-b];
        end
        return r >> (4'(AW) - l);
    endfunction

    // inverse scaling: divide by n, half away from zero
    function automatic logic signed [DW-1:0] scale(input logic signed [DW-1:0] x,
                                                   input logic [3:0] l,
                                                   input logic [CW-1:0] hn);
        logic [DW:0] mag, q;
        mag = x[DW-1] ? ((DW+1)'(0) - (DW+1)'(x)) : (DW+1)'(x);
        q   = (mag + (DW+1)'(hn)) >> l;
        return x[DW-1] ? DW'((DW+1)'(0) - q) : q[DW-1:0];
    endfunction

    r2fft_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    r2fft_twiddle u_twiddle (
        .aclk    (aclk),
        .idx     (tw_idx),
        .inverse (inverse_reg),
        .w_real  (w_real),
        .w_imag  (w_imag)
    );

    r2fft_bfly u_bfly (
        .aclk      (aclk),
        .ctrl      (bf_ctrl),
        .rdata     (mem_rdata),
        .w_real    (w_real),
        .w_imag    (w_imag),
        .sum_data  (sum_data),
        .diff_data (diff_data),
        .sat       (bf_sat)
    );

    always_comb begin
        if (log_points_reg < 4'd1) begin
            lg = 4'd1;
        end else if (log_points_reg > 4'(r2fft_pkg::LOG_MAX)) begin
            lg = 4'(r2fft_pkg::LOG_MAX);
        end else begin
            lg = log_points_reg;
        end
        n_pts   = CW'(1) << lg;
        half_n  = n_pts >> 1;
        new_cnt = load_count_reg + CW'(1);
        // butterfly pair: insert a zero bit at the stage position of k
        low_mask = (AW'(1) << stage_reg) - AW'(1);
        j_addr   = ((AW'(k_reg) & ~low_mask) << 1) | (AW'(k_reg) & low_mask);
        j2_addr  = j_addr | (AW'(1) << stage_reg);
        tw_idx   = (k_reg & low_mask[KW-1:0]) << (4'(KW) - stage_reg);
        sc_re    = scale(signed'(mem_rdata[2*DW-1:DW]), lg, half_n);
        sc_im    = scale(signed'(mem_rdata[DW-1:0]), lg, half_n);
    end

    assign s_ready = (state_reg == r2fft_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_acc   = s_valid && s_ready;

    always_comb begin
        state_next         = state_reg;
        log_points_next    = log_points_reg;
        inverse_next       = inverse_reg;
        load_count_next    = load_count_reg;
        read_count_next    = read_count_reg;
        results_ready_next = results_ready_reg;
        overflow_next      = overflow_reg;
        idx_next           = idx_reg;
        k_next             = k_reg;
        stage_next         = stage_reg;
        last_pt_next       = last_pt_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_point_real_next  = m_point_real_reg;
        m_point_imag_next  = m_point_imag_reg;
        m_last_point_next  = m_last_point_reg;
        m_no_data_next     = m_no_data_reg;
        m_saturated_next   = m_saturated_reg;
        mem_we             = 1'b0;
        mem_waddr          = j_addr;
        mem_wdata          = sum_data;
        mem_raddr          = read_count_reg[AW-1:0];
        bf_ctrl            = '0;

        unique case (state_reg)
            r2fft_pkg::ST_IDLE: begin
                if (s_acc && !s_kind) begin
                    if (load_count_reg == '0) begin
                        results_ready_next = 1'b0;
                        read_count_next    = '0;
                        overflow_next      = 1'b0;
                    end
                    mem_we    = 1'b1;
                    mem_waddr = bitrev(load_count_reg[AW-1:0], lg);
                    mem_wdata = {DW'(s_sample_real), DW'(s_sample_imag)};
                    if (s_last_sample || new_cnt >= n_pts) begin
                        load_count_next = '0;
                        idx_next        = new_cnt;
                        state_next      = r2fft_pkg::ST_FILL;
                    end else begin
                        load_count_next = new_cnt;
                    end
                end else if (s_acc) begin
                    if (results_ready_reg && read_count_reg < n_pts) begin
                        mem_raddr       = read_count_reg[AW-1:0];
                        last_pt_next    = (read_count_reg == n_pts - CW'(1));
                        read_count_next = read_count_reg + CW'(1);
                        if (read_count_reg + CW'(1) >= n_pts) begin
                            results_ready_next = 1'b0;
                        end
                        state_next = r2fft_pkg::ST_READ;
                    end else begin
                        m_valid_next      = 1'b1;
                        m_point_real_next = '0;
                        m_point_imag_next = '0;
                        m_last_point_next = 1'b0;
                        m_no_data_next    = 1'b1;
                        m_saturated_next  = 1'b0;
                    end
                end
            end
            r2fft_pkg::ST_READ: begin
                m_valid_next      = 1'b1;
                m_point_real_next = signed'(mem_rdata[2*DW-1:DW]);
                m_point_imag_next = signed'(mem_rdata[DW-1:0]);
                m_last_point_next = last_pt_reg;
                m_no_data_next    = 1'b0;
                m_saturated_next  = overflow_reg;
                state_next        = r2fft_pkg::ST_IDLE;
            end
            r2fft_pkg::ST_FILL: begin
                if (idx_reg < n_pts) begin
                    mem_we    = 1'b1;
                    mem_waddr = bitrev(idx_reg[AW-1:0], lg);
                    mem_wdata = '0;
                    idx_next  = idx_reg + CW'(1);
                end else begin
                    k_next     = '0;
                    stage_next = '0;
                    state_next = r2fft_pkg::ST_BF_RDA;
                end
            end
            r2fft_pkg::ST_BF_RDA: begin
                mem_raddr  = j_addr;
                state_next = r2fft_pkg::ST_BF_RDB;
            end
            r2fft_pkg::ST_BF_RDB: begin
                mem_raddr     = j2_addr;
                bf_ctrl.cap_a = 1'b1;
                state_next    = r2fft_pkg::ST_BF_MUL;
            end
            r2fft_pkg::ST_BF_MUL: begin
                bf_ctrl.mul_en = 1'b1;
                state_next     = r2fft_pkg::ST_BF_RND;
            end
            r2fft_pkg::ST_BF_RND: begin
                bf_ctrl.rnd_en = 1'b1;
                state_next     = r2fft_pkg::ST_BF_WRA;
            end
            r2fft_pkg::ST_BF_WRA: begin
                bf_ctrl.wr_a  = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = j_addr;
                mem_wdata     = sum_data;
                overflow_next = overflow_reg || bf_sat;
                state_next    = r2fft_pkg::ST_BF_WRB;
            end
            r2fft_pkg::ST_BF_WRB: begin
                mem_we     = 1'b1;
                mem_waddr  = j2_addr;
                mem_wdata  = diff_data;
                state_next = r2fft_pkg::ST_BF_RDA;
                if (CW'(k_reg) == half_n - CW'(1)) begin
                    k_next = '0;
                    if (stage_reg == lg - 4'd1) begin
                        if (inverse_reg) begin
                            idx_next   = '0;
                            state_next = r2fft_pkg::ST_SC_RD;
                        end else begin
                            results_ready_next = 1'b1;
                            read_count_next    = '0;
                            state_next         = r2fft_pkg::ST_IDLE;
                        end
                    end else begin
                        stage_next = stage_reg + 4'd1;
                    end
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            r2fft_pkg::ST_SC_RD: begin
                mem_raddr  = idx_reg[AW-1:0];
                state_next = r2fft_pkg::ST_SC_WR;
            end
            r2fft_pkg::ST_SC_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = {sc_re, sc_im};
                idx_next  = idx_reg + CW'(1);
                if (idx_reg + CW'(1) >= n_pts) begin
                    results_ready_next = 1'b1;
                    read_count_next    = '0;
                    state_next         = r2fft_pkg::ST_IDLE;
                end else begin
                    state_next = r2fft_pkg::ST_SC_RD;
                end
            end
            default: begin
                state_next = r2fft_pkg::ST_IDLE;
            end
        endcase

        // the user must make register writes only while idle; the block itself does not enforce it
        if (cfg_wr_en) begin
            if (cfg_index == r2fft_pkg::REG_LOG_POINTS) begin
                log_points_next    = cfg_data;
                load_count_next    = '0;
                read_count_next    = '0;
                results_ready_next = 1'b0;
                overflow_next      = 1'b0;
            end else if (cfg_index == r2fft_pkg::REG_INVERSE) begin
                inverse_next = cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= r2fft_pkg::ST_IDLE;
            log_points_reg    <= 4'(r2fft_pkg::LOG_MAX);
            inverse_reg       <= 1'b0;
            load_count_reg    <= '0;
            read_count_reg    <= '0;
            results_ready_reg <= 1'b0;
            overflow_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            log_points_reg    <= log_points_next;
            inverse_reg       <= inverse_next;
            load_count_reg    <= load_count_next;
            read_count_reg    <= read_count_next;
            results_ready_reg <= results_ready_next;
            overflow_reg      <= overflow_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg          <= idx_next;
        k_reg            <= k_next;
        stage_reg        <= stage_next;
        last_pt_reg      <= last_pt_next;
        m_point_real_reg <= m_point_real_next;
        m_point_imag_reg <= m_point_imag_next;
        m_last_point_reg <= m_last_point_next;
        m_no_data_reg    <= m_no_data_next;
        m_saturated_reg  <= m_saturated_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_point_real = m_point_real_reg;
    assign m_point_imag = m_point_imag_reg;
    assign m_last_point = m_last_point_reg;
    assign m_no_data    = m_no_data_reg;
    assign m_saturated  = m_saturated_reg;

endmodule
